/* rtl/tmrbank_pkg.sv */
// ----------------------------------------------------------------------------
// tmrbank_pkg
// Shared types and codes for the timer bank: operation and status codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package tmrbank_pkg;

   // operation codes carried on the request channel
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ARM    = 2'd1;
   localparam logic [1:0] OP_REARM  = 2'd2;
   localparam logic [1:0] OP_DISARM = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ARMED     = 2'd1;
   localparam logic [1:0] STAT_ZERO_CNT  = 2'd2;
   localparam logic [1:0] STAT_NOT_ARMED = 2'd3;

   // field widths
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 4;
   localparam int CNT_W   = 31;
   localparam int TAG_W   = 16;
   localparam int STAT_W  = 2;

   // expiry reports per tick and the width of their counter
   localparam int MAX_REPORTS = 16;
   localparam int REP_W       = 5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_FLUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic exec;
      logic walk;
      logic flush;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic walk_done;
      logic req_tick;
   } dp_stat_type;

endpackage

/* rtl/tmrbank_ctrl.sv */
// ----------------------------------------------------------------------------
// tmrbank_ctrl
// Sequencer for the timer bank: takes one request at a time, runs either a
// single slot operation or a walk over all slots, then the final response.
// ----------------------------------------------------------------------------
module tmrbank_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tmrbank_pkg::dp_stat_type   stat,
   output tmrbank_pkg::ctrl_cmd_type  cmd
);
   import tmrbank_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_tick ? S_WALK : S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (stat.walk_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/tmrbank_dp.sv */
// ----------------------------------------------------------------------------
// tmrbank_dp
// Timer bank datapath: slot memories, armed bits, the two-stage slot walk
// with a shared decrementer, pending expiry report and response register.
// ----------------------------------------------------------------------------
module tmrbank_dp #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tmrbank_pkg::OP_W-1:0]          req_op,
   input  logic [tmrbank_pkg::SLOT_W-1:0]        req_slot,
   input  logic [tmrbank_pkg::CNT_W-1:0]         req_count,
   input  logic [tmrbank_pkg::CNT_W-1:0]         req_interval,
   input  logic [tmrbank_pkg::TAG_W-1:0]         req_event_tag,
   input  tmrbank_pkg::ctrl_cmd_type             cmd,
   output tmrbank_pkg::dp_stat_type              stat,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [tmrbank_pkg::STAT_W-1:0]        rsp_status,
   output logic                                  rsp_expired,
   output logic [tmrbank_pkg::SLOT_W-1:0]        rsp_expired_slot,
   output logic [tmrbank_pkg::TAG_W-1:0]         rsp_expired_tag,
   output logic                                  rsp_last
);
   import tmrbank_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int WLK_W = $clog2(NUM_TIMERS + 1);

   // slot storage
   logic [CNT_W-1:0]      cnt_mem_ff [NUM_TIMERS];
   logic [CNT_W-1:0]      ivl_mem_ff [NUM_TIMERS];
   logic [TAG_W-1:0]      tag_mem_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;

   // latched request
   logic [OP_W-1:0]   op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  interval_ff;
   logic [TAG_W-1:0]  tag_ff;

   // walk pipeline
   logic [WLK_W-1:0]  idx_ff, idx_in;
   logic              ex_valid_ff, ex_valid_in;
   logic [IDX_W-1:0]  ex_idx_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic [CNT_W-1:0]  ivl_rd_ff;
   logic [TAG_W-1:0]  tag_rd_ff;

   // pending report
   logic              pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [TAG_W-1:0]  pend_tag_ff;
   logic [REP_W-1:0]  rep_cnt_ff, rep_cnt_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_expired_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              out_load;
   logic [STAT_W-1:0] out_status;
   logic              out_expired;
   logic [SLOT_W-1:0] out_slot;
   logic [TAG_W-1:0]  out_tag;
   logic              out_last;

   logic [IDX_W-1:0]  slot_idx;
   logic              slot_ok;
   logic              slot_armed;
   logic              exec_fire;
   logic [STAT_W-1:0] exec_status;

   logic              ex_armed;
   logic [CNT_W-1:0]  cnt_dec;
   logic              ex_hit;
   logic              ex_report;
   logic              emit;
   logic              adv;
   logic              rd_en;

   logic              wr_en;
   logic              wr_full;
   logic [IDX_W-1:0]  wr_addr;
   logic [CNT_W-1:0]  wr_cnt;
   logic [CNT_W-1:0]  wr_ivl;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff       <= req_op;
         slot_ff     <= req_slot;
         count_ff    <= req_count;
         interval_ff <= req_interval;
         tag_ff      <= req_event_tag;
      end
   end

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign stat.out_free = out_free;
   assign stat.req_tick = (req_op == OP_TICK);

   // single slot operation
   assign slot_idx   = IDX_W'(slot_ff);
   assign slot_ok    = (32'(slot_ff) < NUM_TIMERS);
   assign slot_armed = armed_ff[slot_idx];
   assign exec_fire  = cmd.exec && out_free;

   always_comb begin
      exec_status = STAT_OK;
      if (!slot_ok) begin
         exec_status = STAT_NOT_ARMED;
      end else begin
         unique case (op_ff)
            OP_ARM: begin
               if (slot_armed) begin
                  exec_status = STAT_ARMED;
               end else if (count_ff == '0) begin
                  exec_status = STAT_ZERO_CNT;
               end
            end
            OP_REARM: begin
               if (count_ff == '0) begin
                  exec_status = STAT_ZERO_CNT;
               end else if (!slot_armed) begin
                  exec_status = STAT_NOT_ARMED;
               end
            end
            OP_DISARM: begin
               if (!slot_armed) begin
                  exec_status = STAT_NOT_ARMED;
               end
            end
            default: begin
               exec_status = STAT_OK;
            end
         endcase
      end
   end

   // walk stage: shared decrementer on the slot held in the read registers
   assign ex_armed  = armed_ff[ex_idx_ff];
   assign cnt_dec   = cnt_rd_ff - CNT_W'(1);
   assign ex_hit    = ex_armed && (cnt_dec == '0);
   assign ex_report = ex_hit && (tag_rd_ff != '0) && (rep_cnt_ff < REP_W'(MAX_REPORTS));
   assign emit      = cmd.walk && ex_valid_ff && ex_report && pend_valid_ff;
   assign adv       = !(emit && !out_free);
   assign rd_en     = cmd.walk && adv && (idx_ff < WLK_W'(NUM_TIMERS));

   assign stat.walk_done = (idx_ff == WLK_W'(NUM_TIMERS)) && !ex_valid_ff;

   // walk index and pipeline valid
   always_comb begin
      idx_in      = idx_ff;
      ex_valid_in = ex_valid_ff;
      if (cmd.start) begin
         idx_in      = '0;
         ex_valid_in = 1'b0;
      end else if (cmd.walk && adv) begin
         ex_valid_in = rd_en;
         if (rd_en) begin
            idx_in = idx_ff + WLK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         ex_valid_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         ex_valid_ff <= ex_valid_in;
      end
   end

   // registered slot reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         ex_idx_ff <= idx_ff[IDX_W-1:0];
         cnt_rd_ff <= cnt_mem_ff[idx_ff[IDX_W-1:0]];
         ivl_rd_ff <= ivl_mem_ff[idx_ff[IDX_W-1:0]];
         tag_rd_ff <= tag_mem_ff[idx_ff[IDX_W-1:0]];
      end
   end

   // memory write port, shared by slot operations and the walk
   always_comb begin
      wr_en   = 1'b0;
      wr_full = 1'b0;
      wr_addr = slot_idx;
      wr_cnt  = count_ff;
      wr_ivl  = interval_ff;
      if (exec_fire && slot_ok && (count_ff != '0)) begin
         if (op_ff == OP_ARM && !slot_armed) begin
            wr_en   = 1'b1;
            wr_full = 1'b1;
         end else if (op_ff == OP_REARM) begin
            wr_en = 1'b1;
         end
      end else if (cmd.walk && adv && ex_valid_ff && ex_armed) begin
         wr_en   = 1'b1;
         wr_addr = ex_idx_ff;
         wr_cnt  = ex_hit ? ivl_rd_ff : cnt_dec;
         wr_ivl  = ivl_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem_ff[wr_addr] <= wr_cnt;
         ivl_mem_ff[wr_addr] <= wr_ivl;
      end
      if (wr_full) begin
         tag_mem_ff[wr_addr] <= tag_ff;
      end
   end

   // armed bits
   always_comb begin
      armed_in = armed_ff;
      if (exec_fire && slot_ok) begin
         if (op_ff == OP_ARM && !slot_armed && count_ff != '0) begin
            armed_in[slot_idx] = 1'b1;
         end else if (op_ff == OP_DISARM) begin
            armed_in[slot_idx] = 1'b0;
         end
      end else if (cmd.walk && adv && ex_valid_ff && ex_hit && ivl_rd_ff == '0) begin
         armed_in[ex_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   // pending report, held back until the next one shows whether it is last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      rep_cnt_in    = rep_cnt_ff;
      if (cmd.start) begin
         pend_valid_in = 1'b0;
         rep_cnt_in    = '0;
      end else if (cmd.walk && adv && ex_valid_ff && ex_report) begin
         pend_valid_in = 1'b1;
         rep_cnt_in    = rep_cnt_ff + REP_W'(1);
      end else if (cmd.flush && out_free) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rep_cnt_ff    <= rep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk && adv && ex_valid_ff && ex_report) begin
         pend_slot_ff <= SLOT_W'(ex_idx_ff);
         pend_tag_ff  <= tag_rd_ff;
      end
   end

   // response selection
   always_comb begin
      out_load    = 1'b0;
      out_status  = STAT_OK;
      out_expired = 1'b0;
      out_slot    = '0;
      out_tag     = '0;
      out_last    = 1'b1;
      if (exec_fire) begin
         out_load   = 1'b1;
         out_status = exec_status;
      end else if (emit && out_free) begin
         out_load    = 1'b1;
         out_expired = 1'b1;
         out_slot    = pend_slot_ff;
         out_tag     = pend_tag_ff;
         out_last    = 1'b0;
      end else if (cmd.flush && out_free) begin
         out_load = 1'b1;
         if (pend_valid_ff) begin
            out_expired = 1'b1;
            out_slot    = pend_slot_ff;
            out_tag     = pend_tag_ff;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff  <= out_status;
         rsp_expired_ff <= out_expired;
         rsp_slot_ff    <= out_slot;
         rsp_tag_ff     <= out_tag;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_expired      = rsp_expired_ff;
   assign rsp_expired_slot = rsp_slot_ff;
   assign rsp_expired_tag  = rsp_tag_ff;
   assign rsp_last         = rsp_last_ff;

   // expiry reports always carry an ok status
   a_expiry_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_expired_ff) |-> (rsp_status_ff == STAT_OK))
      else $error("expiry response with non-ok status");

   // never more reports than the per-tick limit
   a_rep_limit: assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= REP_W'(MAX_REPORTS))
      else $error("report count beyond limit");

   // a held report has been counted
   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (rep_cnt_ff != '0))
      else $error("pending report without count");

   // a report held back by a stalled response is not lost
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (emit && !out_free) |=> (pend_valid_ff && $stable(pend_slot_ff)))
      else $error("pending report changed while stalled");

endmodule

/* rtl/timer_bank_arm_tick_expire_unit.sv */
// ----------------------------------------------------------------------------
// timer_bank_arm_tick_expire_unit
// Bank of NUM_TIMERS software timers with arm, rearm, disarm and tick.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_valid, held while req_stall is high) carries one
//   operation. Arm, rearm and disarm each give one response with last set.
//   A tick walks every slot with one shared decrementer, reloading or
//   disarming slots that reach zero, and gives one response per expiry of
//   a slot with a nonzero tag (at most MAX_REPORTS per tick), in ascending
//   slot order, the final one marked last; a tick with no reported expiry
//   gives one empty response. A slot operation's response is registered
//   and the next request is taken once the controller is idle again. A
//   tick reads one slot a cycle from the slot memories unless the walk is
//   held by a stalled receiver; its last response comes from the final
//   flush after the walk. Requests are taken one at a time.
//   Responses sit in an output register with one expiry report held behind
//   it, so a stalled receiver holds the walk only when a further report is
//   ready; slot operations and the final tick response wait for the output.
//   Reset (synchronous) disarms every slot and empties the response
//   register; slot counts, intervals and tags are written by arm.
// ----------------------------------------------------------------------------
module timer_bank_arm_tick_expire_unit #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tmrbank_pkg::OP_W-1:0]          req_op,
   input  logic [tmrbank_pkg::SLOT_W-1:0]        req_slot,
   input  logic [tmrbank_pkg::CNT_W-1:0]         req_count,
   input  logic [tmrbank_pkg::CNT_W-1:0]         req_interval,
   input  logic [tmrbank_pkg::TAG_W-1:0]         req_event_tag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tmrbank_pkg::STAT_W-1:0]        rsp_status,
   output logic                                  rsp_expired,
   output logic [tmrbank_pkg::SLOT_W-1:0]        rsp_expired_slot,
   output logic [tmrbank_pkg::TAG_W-1:0]         rsp_expired_tag,
   output logic                                  rsp_last
);
   import tmrbank_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   tmrbank_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot storage and walk datapath
   tmrbank_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_count        (req_count),
      .req_interval     (req_interval),
      .req_event_tag    (req_event_tag),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_expired      (rsp_expired),
      .rsp_expired_slot (rsp_expired_slot),
      .rsp_expired_tag  (rsp_expired_tag),
      .rsp_last         (rsp_last)
   );

endmodule
